// ===== rtl/core/drf_pkg.sv =====
// ----------------------------------------------------------------------------
// drf_pkg: shared types and codes of the dual reader FIFO
// Record, transfer payload and cell control types, plus command and status
// codes used by the FIFO cells, the top level and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package drf_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_ALREADY = 3'd2,
        ST_END     = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic        reader;
        logic [15:0] sensor_id;
        logic [63:0] reading_bits;
        logic [31:0] timestamp;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] out_sensor_id;
        logic [63:0] out_reading_bits;
        logic [31:0] out_timestamp;
    } t_out_item;

    typedef struct packed {
        logic [15:0] sensor_id;
        logic [63:0] reading_bits;
        logic [31:0] timestamp;
    } t_record;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/drf_cell.sv =====
// ----------------------------------------------------------------------------
// drf_cell: one storage cell of the FIFO chain
// Holds one record. On a shift it takes the record of its neighbour further
// from the head; on a load it takes the record being inserted.
// ----------------------------------------------------------------------------
`default_nettype none

module drf_cell
    import drf_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_record    i_next,
    input  t_record    i_ins,
    output t_record    o_rec
);

    t_record r_rec;

    // Shift and load never coincide: one operation is transferred per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_rec <= i_next;
        end else if (i_ctrl.load) begin
            r_rec <= i_ins;
        end
    end

    assign o_rec = r_rec;

endmodule

`default_nettype wire

// ===== rtl/core/dual_reader_fifo.sv =====
// ----------------------------------------------------------------------------
// dual_reader_fifo: sensor record FIFO shared by two readers
// Input channel carries insert or remove commands; output channel carries
// exactly one status transfer per accepted command, with the head record
// attached on a successful remove.
// Storage is a row of DEPTH cells with the head always in cell 0; an insert
// loads the cell at the fill count and a completed remove shifts the whole
// row one cell towards the head, all cells at once.
// The result is registered and appears in the cycle after the command is transferred.
// One command is taken per cycle while o_in_stall is low; the result is decided from the head cell
// and the control registers in the cycle of the transfer.
// The output register frees the input side: a new command is taken whenever
// the output register is empty or being emptied. While the receiver stalls
// with a result waiting, o_in_stall is raised and the result is held.
// Reset empties the FIFO, clears both readers' taken marks and the end flag;
// cell contents are not cleared and are never shown before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_reader_fifo
    import drf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [1:0]    r_taken;
    logic          r_end;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [CW-1:0] n_count;
    logic [1:0]    n_taken;
    logic          n_end;
    t_out_item     n_out;

    logic          w_accept;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    t_record       w_ins;
    t_record       w_rec [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_ins.sensor_id    = i_in_data.sensor_id;
    assign w_ins.reading_bits = i_in_data.reading_bits;
    assign w_ins.timestamp    = i_in_data.timestamp;

    always_comb begin
        n_out   = '0;
        n_out.status = ST_OK;
        n_taken = r_taken;
        n_end   = r_end;
        w_push  = 1'b0;
        w_pop   = 1'b0;
        if (i_in_data.cmd == CMD_INSERT) begin
            if (w_full) begin
                n_out.status = ST_FULL;
            end else begin
                w_push = w_accept;
            end
        end else if (w_empty) begin
            n_out.status = r_end ? ST_END : ST_EMPTY;
        end else if (r_taken[i_in_data.reader]) begin
            n_out.status = ST_ALREADY;
        end else begin
            n_out.out_sensor_id    = w_rec[0].sensor_id;
            n_out.out_reading_bits = w_rec[0].reading_bits;
            n_out.out_timestamp    = w_rec[0].timestamp;
            n_taken[i_in_data.reader] = 1'b1;
            // The head leaves once both readers have had it.
            if (n_taken == 2'b11) begin
                n_taken = 2'b00;
                w_pop   = w_accept;
            end
            if (w_rec[0].sensor_id == '0) begin
                n_end        = 1'b1;
                n_out.status = ST_END;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + CW'(1);
        end else if (w_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_taken     <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_taken     <= n_taken;
                r_end       <= n_end;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctrl w_ctrl;
        t_record    w_next;

        assign w_ctrl.shift = w_pop;
        assign w_ctrl.load  = w_push && (r_count == CW'(g));

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_rec[g+1];
        end

        drf_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_next (w_next),
            .i_ins  (w_ins),
            .o_rec  (w_rec[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/drf_checker.sv =====
// ----------------------------------------------------------------------------
// drf_checker: port-level checks of the dual reader FIFO
// Watches the top level's channels and is attached to it by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module drf_port_checker
    import drf_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input t_in_item  i_in_data,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_item o_out_data
);

    // A held result keeps its contents until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Every transferred command gives a result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("command without result");

    // The input side only stalls behind a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no result waiting");

    // Empty, already-taken and full statuses carry zero record fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_EMPTY || o_out_data.status == ST_ALREADY
                        || o_out_data.status == ST_FULL)
        |-> o_out_data.out_sensor_id == '0 && o_out_data.out_reading_bits == '0
            && o_out_data.out_timestamp == '0)
        else $error("record fields set without a record");

endmodule

bind dual_reader_fifo drf_port_checker u_drf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
